FILE: design/opts_pkg.sv
// Shared types, constants and the window clamp for the operating point table selector.
`default_nettype none

package opts_pkg;

	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

	localparam logic [1:0] MODE_POWERSAVE   = 2'd0;
	localparam logic [1:0] MODE_PERFORMANCE = 2'd1;

	typedef enum logic [2:0] {
		REG_WINDOW_MIN     = 3'd0,
		REG_WINDOW_MAX     = 3'd1,
		REG_OPERATING_MODE = 3'd2,
		REG_LIMIT_MIN      = 3'd3,
		REG_LIMIT_MAX      = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic [31:0] window_min;
		logic [31:0] window_max;
		logic [1:0]  operating_mode;
		logic [31:0] limit_min;
		logic [31:0] limit_max;
	} cfg_t;

	typedef struct packed {
		logic [31:0] entry_freq;
		logic        entry_valid;
		logic        last_entry;
	} item_t;

	typedef struct packed {
		logic        found;
		logic [5:0]  best_index;
		logic [31:0] best_freq;
		logic [31:0] table_min;
		logic [31:0] table_max;
		logic        table_empty;
		logic [6:0]  in_window_count;
		logic [31:0] verified_min;
		logic [31:0] verified_max;
		logic        overflow;
	} result_t;

	// Per-table accumulators of fixed width.
	typedef struct packed {
		logic [31:0] best_freq;
		logic        found;
		logic [31:0] run_min;
		logic [31:0] run_max;
		logic [31:0] nearest_above;
		logic        seen;
		logic        overflow;
	} acc_t;

	localparam acc_t ACC_CLEAR = '{
		best_freq:     32'd0,
		found:         1'b0,
		run_min:       ALL_ONES,
		run_max:       32'd0,
		nearest_above: ALL_ONES,
		seen:          1'b0,
		overflow:      1'b0
	};

	typedef struct packed {
		logic [31:0] lo;
		logic [31:0] hi;
	} window_t;

	// Clamp a window to [lo, hi]; the order of the steps matters.
	function automatic window_t clamp_window(window_t w, logic [31:0] lo, logic [31:0] hi);
		window_t r;
		r = w;
		if (r.lo < lo) r.lo = lo;
		if (r.hi < lo) r.hi = lo;
		if (r.lo > hi) r.lo = hi;
		if (r.hi > hi) r.hi = hi;
		if (r.lo > r.hi) r.lo = r.hi;
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: design/operating_point_table_select_unit.sv
// Top level of the operating point table selector: handshakes, state and result register.
`default_nettype none

// A table entry is registered on acceptance in the input stage and folded from there into the
// running state, which for a last entry also loads the result register.
// Throughput: one entry per cycle, set by the single update pass between input and state.
// The input stage stalls only while a finished result waits and another last entry arrives.
// Reset (arst_n low, asynchronous): registers but item_s1 and result reset, pipeline empty.

module operating_point_table_select_unit #(
	parameter int MAX_ENTRIES = 64
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     cfg_write,
	input  wire  [2:0]              cfg_index,
	input  wire  [31:0]             cfg_data,
	input  wire                     item_valid,
	output logic                    item_ready,
	input  opts_pkg::item_t         item,
	output logic                    result_valid,
	input  wire                     result_ready,
	output opts_pkg::result_t       result
);

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int IW = $clog2(MAX_ENTRIES);

	// Configuration registers.
	opts_pkg::cfg_t cfg_q;

	// Input stage.
	opts_pkg::item_t item_s1;
	logic            valid_s1;

	// Per-table state.
	opts_pkg::acc_t  acc_q;
	logic [CW-1:0]   entry_count_q;
	logic [IW-1:0]   best_idx_q;
	logic [CW-1:0]   win_count_q;

	// Next-state values from the update pass.
	opts_pkg::acc_t    acc_nxt;
	logic [CW-1:0]     entry_count_nxt;
	logic [IW-1:0]     best_idx_nxt;
	logic [CW-1:0]     win_count_nxt;
	opts_pkg::result_t result_nxt;

	logic advance;

	// Advance the input stage unless it holds a last entry and the result register is
	// still full; a non-last entry never needs the output side.
	assign advance    = valid_s1 && (!item_s1.last_entry || !result_valid || result_ready);
	assign item_ready = !valid_s1 || advance;

	// Configuration writes; an index beyond the register list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_min     <= 32'd0;
			cfg_q.window_max     <= opts_pkg::ALL_ONES;
			cfg_q.operating_mode <= opts_pkg::MODE_PERFORMANCE;
			cfg_q.limit_min      <= 32'd0;
			cfg_q.limit_max      <= opts_pkg::ALL_ONES;
		end else if (cfg_write) begin
			case (cfg_index)
				opts_pkg::REG_WINDOW_MIN:     cfg_q.window_min     <= cfg_data;
				opts_pkg::REG_WINDOW_MAX:     cfg_q.window_max     <= cfg_data;
				opts_pkg::REG_OPERATING_MODE: cfg_q.operating_mode <= cfg_data[1:0];
				opts_pkg::REG_LIMIT_MIN:      cfg_q.limit_min      <= cfg_data;
				opts_pkg::REG_LIMIT_MAX:      cfg_q.limit_max      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register: capture a transaction whenever the stage is free or draining.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) item_s1 <= item;
	end

	opts_entry_update #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_update (
		.cfg             (cfg_q),
		.item            (item_s1),
		.acc             (acc_q),
		.entry_count     (entry_count_q),
		.best_idx        (best_idx_q),
		.win_count       (win_count_q),
		.acc_nxt         (acc_nxt),
		.entry_count_nxt (entry_count_nxt),
		.best_idx_nxt    (best_idx_nxt),
		.win_count_nxt   (win_count_nxt),
		.result          (result_nxt)
	);

	// Per-table state: fold the entry in, or start a fresh table after a last entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q         <= opts_pkg::ACC_CLEAR;
			entry_count_q <= '0;
			best_idx_q    <= '0;
			win_count_q   <= '0;
		end else if (advance) begin
			if (item_s1.last_entry) begin
				acc_q         <= opts_pkg::ACC_CLEAR;
				entry_count_q <= '0;
				best_idx_q    <= '0;
				win_count_q   <= '0;
			end else begin
				acc_q         <= acc_nxt;
				entry_count_q <= entry_count_nxt;
				best_idx_q    <= best_idx_nxt;
				win_count_q   <= win_count_nxt;
			end
		end
	end

	// Result register: load on a last entry, hold until the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance && item_s1.last_entry) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last_entry) result <= result_nxt;
	end

endmodule

`default_nettype wire

FILE: design/opts_entry_update.sv
// Per-entry update of the selection, statistics and verify state, and result formation.
`default_nettype none

module opts_entry_update #(
	parameter int MAX_ENTRIES = 64
) (
	input  opts_pkg::cfg_t                        cfg,
	input  opts_pkg::item_t                       item,
	input  opts_pkg::acc_t                        acc,
	input  logic [$clog2(MAX_ENTRIES+1)-1:0]      entry_count,
	input  logic [$clog2(MAX_ENTRIES)-1:0]        best_idx,
	input  logic [$clog2(MAX_ENTRIES+1)-1:0]      win_count,
	output opts_pkg::acc_t                        acc_nxt,
	output logic [$clog2(MAX_ENTRIES+1)-1:0]      entry_count_nxt,
	output logic [$clog2(MAX_ENTRIES)-1:0]        best_idx_nxt,
	output logic [$clog2(MAX_ENTRIES+1)-1:0]      win_count_nxt,
	output opts_pkg::result_t                     result
);

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int IW = $clog2(MAX_ENTRIES);
	localparam logic [CW-1:0] DEPTH = CW'(MAX_ENTRIES);

	opts_pkg::window_t vwin;
	opts_pkg::window_t fwin;
	logic [31:0] freq;
	logic in_policy;
	logic in_verify;
	logic take;

	assign freq = item.entry_freq;

	always_comb begin
		vwin = opts_pkg::clamp_window('{lo: cfg.window_min, hi: cfg.window_max},
			cfg.limit_min, cfg.limit_max);
		in_policy = (freq >= cfg.window_min) && (freq <= cfg.window_max);
		in_verify = (freq >= vwin.lo) && (freq <= vwin.hi);
		case (cfg.operating_mode)
			opts_pkg::MODE_PERFORMANCE: take = !acc.found || (acc.best_freq <= freq);
			opts_pkg::MODE_POWERSAVE:   take = !acc.found || (acc.best_freq >= freq);
			default:                    take = 1'b0;
		endcase

		acc_nxt         = acc;
		entry_count_nxt = entry_count;
		best_idx_nxt    = best_idx;
		win_count_nxt   = win_count;

		if (entry_count >= DEPTH) begin
			acc_nxt.overflow = 1'b1;
		end else begin
			if (item.entry_valid) begin
				acc_nxt.seen = 1'b1;
				if (freq < acc.run_min) acc_nxt.run_min = freq;
				if (freq > acc.run_max) acc_nxt.run_max = freq;
				if (in_policy && take) begin
					acc_nxt.best_freq = freq;
					acc_nxt.found     = 1'b1;
					best_idx_nxt      = entry_count[IW-1:0];
				end
				if (in_verify) begin
					if (win_count < DEPTH) win_count_nxt = win_count + CW'(1);
				end else if ((freq > vwin.hi) && (freq < acc.nearest_above)) begin
					acc_nxt.nearest_above = freq;
				end
			end
			entry_count_nxt = entry_count + CW'(1);
		end

		// Raise max to the next larger frequency when the window held nothing.
		fwin = vwin;
		if (win_count_nxt == '0) fwin.hi = acc_nxt.nearest_above;
		fwin = opts_pkg::clamp_window(fwin, cfg.limit_min, cfg.limit_max);

		result.found           = acc_nxt.found;
		result.best_index      = acc_nxt.found ? 6'(best_idx_nxt) : 6'd0;
		result.best_freq       = acc_nxt.found ? acc_nxt.best_freq : 32'd0;
		result.table_min       = acc_nxt.run_min;
		result.table_max       = acc_nxt.run_max;
		result.table_empty     = !acc_nxt.seen;
		result.in_window_count = 7'(win_count_nxt);
		result.verified_min    = fwin.lo;
		result.verified_max    = fwin.hi;
		result.overflow        = acc_nxt.overflow;
	end

endmodule

`default_nettype wire
